// ----- rtl/mbpf_pkg.sv -----
// Shared constants, types and helper functions for the masked byte pattern finder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mbpf_pkg;

   // Sizing
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int OFFSET_BITS       = 32;
   localparam int REG_BYTES         = 16;   // pattern bytes held by the registers
   localparam int BYTE_W            = 8;
   localparam int LEN_W             = 5;
   localparam int STRICT_W          = 16;
   localparam int OUT_OFFSET_W      = 32;
   localparam int CSR_DATA_W        = 64;
   localparam int CSR_IDX_W         = 2;

   // Stored history bytes (the current byte is not stored)
   localparam int WIN_DEPTH = (MAX_PATTERN_BYTES > 1) ? MAX_PATTERN_BYTES - 1 : 1;
   // Index into the compare window, current byte at distance 0
   localparam int WIN_IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_STRICT_MASK  = 2'd2,
      CSR_PATTERN_LEN  = 2'd3
   } csr_idx_type;

   // Configuration as seen by the scan logic
   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low;
      logic [CSR_DATA_W-1:0] pattern_high;
      logic [STRICT_W-1:0]   strict_mask;
      logic [LEN_W-1:0]      pattern_length;
   } cfg_type;

   // One result item
   typedef struct packed {
      logic                    match_found;
      logic [OUT_OFFSET_W-1:0] match_offset;
   } result_type;

   // Pattern byte i; bytes past the registers read as zero
   function automatic logic [BYTE_W-1:0] pattern_byte(cfg_type cfg, int i);
      logic [2*CSR_DATA_W-1:0] all_bytes;
      all_bytes = {cfg.pattern_high, cfg.pattern_low};
      if (i < REG_BYTES) begin
         pattern_byte = all_bytes[BYTE_W*(i % REG_BYTES) +: BYTE_W];
      end else begin
         pattern_byte = '0;
      end
   endfunction

   // Strict bit i; positions past the registers are wildcards
   function automatic logic position_strict(cfg_type cfg, int i);
      if (i < STRICT_W) begin
         position_strict = cfg.strict_mask[i % STRICT_W];
      end else begin
         position_strict = 1'b0;
      end
   endfunction

endpackage

// ----- rtl/mbpf_if.sv -----
// Valid/ready channel interfaces: byte input, result output and register write.
// Depends on mbpf_pkg.
`timescale 1ns / 1ps

interface mbpf_req_if import mbpf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_buffer;

   modport source (output valid, data_byte, end_of_buffer, input ready);
   modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

interface mbpf_rsp_if import mbpf_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    match_found;
   logic [OUT_OFFSET_W-1:0] match_offset;

   modport source (output valid, match_found, match_offset, input ready);
   modport sink   (input valid, match_found, match_offset, output ready);
endinterface

interface mbpf_csr_if import mbpf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/masked_byte_pattern_finder_top.sv -----
// Masked byte pattern finder, top level: register file, scan stage, result register.
// Depends on mbpf_pkg, mbpf_if, mbpf_csr, mbpf_scan and mbpf_out.
`timescale 1ns / 1ps

// Streams a buffer one byte per transfer on req_ch and, on the byte flagged
// end_of_buffer, returns one result on rsp_ch: whether the configured pattern
// (up to 16 bytes, each position either strict or wildcard by strict_mask)
// occurs wholly inside the buffer, and the offset of its first start. A
// pattern length of zero or above 16, or longer than the buffer, gives not
// found. The byte counter saturates at 2^32-1, after which bytes are neither
// counted nor able to complete a match. The block takes one byte every clock
// cycle unless stalled: each byte is held in an input register and compared
// against the whole window, and the result for a final byte passes from the
// input register into the output register. Input stalls only while a final
// byte waits behind a result that has not yet been taken. Register writes on
// csr_ch are always accepted and belong between buffers.
module masked_byte_pattern_finder_top import mbpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mbpf_req_if.sink    req_ch,
   mbpf_rsp_if.source  rsp_ch,
   mbpf_csr_if.sink    csr_ch
);

   cfg_type    cfg;
   logic       res_valid;
   result_type res;
   logic       slot_free;

   // Configuration registers
   mbpf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // Byte window and match search
   mbpf_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_ch),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result register
   mbpf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .slot_free (slot_free),
      .rsp       (rsp_ch)
   );

endmodule

// ----- rtl/mbpf_csr.sv -----
// Configuration register file: pattern bytes, strict mask and pattern length.
// Depends on mbpf_pkg and mbpf_csr_if.
`timescale 1ns / 1ps

module mbpf_csr import mbpf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mbpf_csr_if.sink   csr,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   // Writes are always accepted
   assign csr.ready = 1'b1;
   assign wr_en     = csr.valid && csr.ready;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_idx_type'(csr.index))
            CSR_PATTERN_LOW:  cfg_in.pattern_low    = csr.data;
            CSR_PATTERN_HIGH: cfg_in.pattern_high   = csr.data;
            CSR_STRICT_MASK:  cfg_in.strict_mask    = csr.data[STRICT_W-1:0];
            CSR_PATTERN_LEN:  cfg_in.pattern_length = csr.data[LEN_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/mbpf_scan.sv -----
// Input register, byte history window, position counter and masked window compare.
// Depends on mbpf_pkg and mbpf_req_if.
`timescale 1ns / 1ps

module mbpf_scan import mbpf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   mbpf_req_if.sink   req,
   input  logic       slot_free,
   output logic       res_valid,
   output result_type res
);

   // Input register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              accept;
   logic              advance;

   // Scan state
   logic [OFFSET_BITS-1:0] pos_ff;
   logic [OFFSET_BITS-1:0] pos_in;
   logic                   have_ff;
   logic                   have_in;
   logic [OFFSET_BITS-1:0] first_ff;
   logic [OFFSET_BITS-1:0] first_in;
   logic [BYTE_W-1:0]      recent_ff [WIN_DEPTH];
   logic [BYTE_W-1:0]      recent_in [WIN_DEPTH];

   // Compare
   logic [BYTE_W-1:0]      hist [MAX_PATTERN_BYTES];
   logic                   hit;
   logic                   saturated;
   logic                   upd_have;
   logic [OFFSET_BITS-1:0] upd_first;

   // A final byte moves on only when the result register can take it
   assign advance   = s1_valid_ff && (!s1_last_ff || slot_free);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   assign saturated = (pos_ff == '1);

   // Window compare: pattern byte i lines up with the byte length-1-i back
   always_comb begin
      hist[0] = s1_byte_ff;
      for (int d = 1; d < MAX_PATTERN_BYTES; d++) begin
         hist[d] = recent_ff[d-1];
      end
      hit = (cfg.pattern_length != '0)
         && (int'(cfg.pattern_length) <= MAX_PATTERN_BYTES)
         && (pos_ff >= OFFSET_BITS'(cfg.pattern_length - 1'b1));
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (i < int'(cfg.pattern_length)) begin
            if (position_strict(cfg, i)
               && (pattern_byte(cfg, i)
                  != hist[WIN_IDX_W'(int'(cfg.pattern_length) - 1 - i)])) begin
               hit = 1'b0;
            end
         end
      end
   end

   // First match bookkeeping; a saturated counter blocks new matches
   always_comb begin
      upd_have  = have_ff;
      upd_first = first_ff;
      if (!saturated && !have_ff && hit) begin
         upd_have  = 1'b1;
         upd_first = pos_ff - OFFSET_BITS'(cfg.pattern_length - 1'b1);
      end
   end

   // Next state; the final byte clears the scan for the next buffer
   always_comb begin
      pos_in    = pos_ff;
      have_in   = have_ff;
      first_in  = first_ff;
      recent_in = recent_ff;
      if (advance) begin
         have_in  = upd_have;
         first_in = upd_first;
         if (!saturated) begin
            pos_in       = pos_ff + 1'b1;
            recent_in[0] = s1_byte_ff;
            for (int k = 1; k < WIN_DEPTH; k++) begin
               recent_in[k] = recent_ff[k-1];
            end
         end
         if (s1_last_ff) begin
            pos_in   = '0;
            have_in  = 1'b0;
            first_in = '0;
         end
      end
   end

   // Result toward the output register
   assign res_valid        = advance && s1_last_ff;
   assign res.match_found  = upd_have;
   assign res.match_offset = upd_have ? OUT_OFFSET_W'(upd_first) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
         have_ff     <= 1'b0;
         first_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff      <= pos_in;
         have_ff     <= have_in;
         first_ff    <= first_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req.data_byte;
         s1_last_ff <= req.end_of_buffer;
      end
      recent_ff <= recent_in;
   end

endmodule

// ----- rtl/mbpf_out.sv -----
// Result register driving the response channel.
// Depends on mbpf_pkg and mbpf_rsp_if.
`timescale 1ns / 1ps

module mbpf_out import mbpf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        res_valid,
   input  result_type  res,
   output logic        slot_free,
   mbpf_rsp_if.source  rsp
);

   logic       out_valid_ff;
   result_type out_data_ff;

   // Room when empty or when the held result transfers this cycle
   assign slot_free = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.match_found  = out_data_ff.match_found;
   assign rsp.match_offset = out_data_ff.match_offset;

endmodule

// ----- test/mbpf_match_monitor.sv -----
// Passive monitor for the masked byte pattern finder: tracks register writes and
// byte transfers, predicts each buffer's result and compares it with rsp_ch.
// Depends on mbpf_pkg and the channel interfaces in mbpf_if.
`timescale 1ns / 1ps

module mbpf_match_monitor import mbpf_pkg::*; (
   input  logic clock,
   input  logic reset,
   mbpf_req_if  req_ch,
   mbpf_rsp_if  rsp_ch,
   mbpf_csr_if  csr_ch,
   output int   mismatch_count,
   output int   outstanding
);

   // Register copy and scan state of the predictor
   cfg_type                regs;
   logic [BYTE_W-1:0]      history [WIN_DEPTH];   // newest byte in entry 0
   logic [OFFSET_BITS-1:0] position;
   logic                   seen_match;
   logic [OFFSET_BITS-1:0] match_start;
   result_type             expected_results [$];

   // Clear the per-buffer scan state
   task automatic clear_scan();
      for (int k = 0; k < WIN_DEPTH; k++) begin
         history[k] = '0;
      end
      position    = '0;
      seen_match  = 1'b0;
      match_start = '0;
   endtask

   // True when the pattern ends on the current byte
   function automatic logic pattern_ends_here(logic [BYTE_W-1:0] current);
      int                      len;
      logic [BYTE_W-1:0]       seen;
      logic [BYTE_W-1:0]       wanted;
      logic [2*CSR_DATA_W-1:0] all_bytes;
      len       = int'(regs.pattern_length);
      all_bytes = {regs.pattern_high, regs.pattern_low};
      if (len == 0 || len > MAX_PATTERN_BYTES) return 1'b0;
      // whole pattern must lie inside this buffer
      if (position < OFFSET_BITS'(len - 1)) return 1'b0;
      for (int i = 0; i < len; i++) begin
         seen   = (i == len - 1) ? current : history[len - 2 - i];
         wanted = (i < 2 * CSR_DATA_W / BYTE_W) ? BYTE_W'(all_bytes >> (BYTE_W * i)) : '0;
         if (i < STRICT_W && regs.strict_mask[i] && wanted != seen) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Advance the prediction by one byte; a final byte yields one result
   task automatic take_byte(logic [BYTE_W-1:0] current, logic last);
      result_type res;
      if (position != '1) begin
         if (!seen_match && pattern_ends_here(current)) begin
            seen_match  = 1'b1;
            match_start = position - OFFSET_BITS'(regs.pattern_length) + 1'b1;
         end
         position = position + 1'b1;
         for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            history[k] = history[k - 1];
         end
         history[0] = current;
      end
      if (last) begin
         res.match_found  = seen_match;
         res.match_offset = seen_match ? match_start[OUT_OFFSET_W-1:0] : '0;
         expected_results.push_back(res);
         clear_scan();
      end
   endtask

   // Compare one result transfer with the oldest expectation
   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result: found %0b offset %0d", $time,
                  rsp_ch.match_found, rsp_ch.match_offset);
         mismatch_count++;
         return;
      end
      want = expected_results.pop_front();
      if (rsp_ch.match_found !== want.match_found) begin
         $display("%0t: match_found expected %0b actual %0b", $time,
                  want.match_found, rsp_ch.match_found);
         mismatch_count++;
      end
      if (rsp_ch.match_offset !== want.match_offset) begin
         $display("%0t: match_offset expected %0d actual %0d", $time,
                  want.match_offset, rsp_ch.match_offset);
         mismatch_count++;
      end
   endtask

   // Results are compared before new expectations are queued in the same cycle
   always @(posedge clock) begin
      if (reset) begin
         regs = '0;
         clear_scan();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result();
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_idx_type'(csr_ch.index))
               CSR_PATTERN_LOW:  regs.pattern_low    = csr_ch.data;
               CSR_PATTERN_HIGH: regs.pattern_high   = csr_ch.data;
               CSR_STRICT_MASK:  regs.strict_mask    = csr_ch.data[STRICT_W-1:0];
               CSR_PATTERN_LEN:  regs.pattern_length = csr_ch.data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            take_byte(req_ch.data_byte, req_ch.end_of_buffer);
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ----- test/tb_top.sv -----
// Testbench top for the masked byte pattern finder: clock, reset, register
// settings, byte stimulus with random idling, and the verdict.
// Depends on mbpf_pkg, mbpf_if, the block's RTL and mbpf_match_monitor.
`timescale 1ns / 1ps

module tb_top;
   import mbpf_pkg::*;

   logic clock;
   logic reset;

   mbpf_req_if req_ch ();
   mbpf_rsp_if rsp_ch ();
   mbpf_csr_if csr_ch ();

   int mismatch_count;
   int outstanding;
   int send_idle_pct;
   int rsp_stall_pct;
   int bytes_sent;

   // Stimulus copy of the pattern registers
   logic [CSR_DATA_W-1:0] pattern_lo;
   logic [CSR_DATA_W-1:0] pattern_hi;
   logic [STRICT_W-1:0]   strict_bits;
   logic [LEN_W-1:0]      pattern_len;

   masked_byte_pattern_finder_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   mbpf_match_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Result side backpressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.data_byte     <= value;
      req_ch.end_of_buffer <= last;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
   endtask

   task automatic send_buffer(input logic [BYTE_W-1:0] seq [$]);
      for (int i = 0; i < seq.size(); i++) begin
         send_byte(seq[i], i == seq.size() - 1);
      end
   endtask

   // Hold the sender until every result is in, then let the pipeline settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write
   task automatic csr_transfer(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // Write all four registers; unused upper data bits carry noise
   task automatic apply_setting(input logic [CSR_DATA_W-1:0] lo, input logic [CSR_DATA_W-1:0] hi,
                                input logic [STRICT_W-1:0] mask, input logic [LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] noise;
      noise       = {$urandom, $urandom};
      pattern_lo  = lo;
      pattern_hi  = hi;
      strict_bits = mask;
      pattern_len = len;
      csr_transfer(CSR_PATTERN_LOW, lo);
      csr_transfer(CSR_PATTERN_HIGH, hi);
      csr_transfer(CSR_STRICT_MASK, {noise[CSR_DATA_W-1:STRICT_W], mask});
      csr_transfer(CSR_PATTERN_LEN, {noise[CSR_DATA_W-1:LEN_W], len});
      csr_ch.valid <= 1'b0;
   endtask

   // Random buffer seeded with pattern bytes and whole or clipped pattern copies
   task automatic send_random_buffer();
      logic [BYTE_W-1:0]       seq [$];
      logic [2*CSR_DATA_W-1:0] all_bytes;
      int n, used_len, start, copies, pick;
      all_bytes = {pattern_hi, pattern_lo};
      used_len  = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pattern_len);
      pick      = $urandom_range(99);
      n = (pick < 75) ? $urandom_range(1, 24) : (pick < 92) ? $urandom_range(25, 60)
                                                            : $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(1))
            seq.push_back(BYTE_W'($urandom));
         else
            seq.push_back(BYTE_W'(all_bytes >> (BYTE_W * $urandom_range(15))));
      end
      copies = (used_len == 0) ? 0 : $urandom_range(2);
      for (int c = 0; c < copies; c++) begin
         // start may fall before or past the buffer so copies get clipped
         start = int'($urandom_range(0, n + used_len)) - used_len;
         for (int i = 0; i < used_len; i++) begin
            if (start + i >= 0 && start + i < n) begin
               seq[start + i] = strict_bits[i] ? BYTE_W'(all_bytes >> (BYTE_W * i))
                                               : BYTE_W'($urandom);
            end
         end
      end
      send_buffer(seq);
   endtask

   initial begin
      logic [BYTE_W-1:0] seq [$];
      int                setting_bytes;
      logic [LEN_W-1:0]  len;

      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.data_byte     = '0;
      req_ch.end_of_buffer = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = CSR_PATTERN_LOW;
      csr_ch.data          = '0;
      send_idle_pct        = 0;
      rsp_stall_pct        = 0;
      bytes_sent           = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: 3-byte pattern AB ?? FF with the middle byte a wildcard
      apply_setting(64'h0000_0000_00FF_00AB, '1, 16'h0005, 5'd3);
      seq = '{8'hAB, 8'h77, 8'hFF};                        // match at offset 0
      send_buffer(seq);
      seq = '{8'h00, 8'hAB, 8'h12, 8'hFF, 8'hAB, 8'h34, 8'hFF};  // first of two matches
      send_buffer(seq);
      seq = '{8'hAB, 8'hFF};                               // buffer shorter than pattern
      send_buffer(seq);
      seq = '{8'hFF};
      send_buffer(seq);
      wait_drained();

      // Zero length never matches, even against an all-zero strict pattern
      apply_setting('0, '0, '1, 5'd0);
      seq = '{8'h00, 8'h00};
      send_buffer(seq);
      wait_drained();

      // Length above the pattern capacity never matches
      apply_setting('0, '0, '0, 5'd31);
      seq = '{8'h00, 8'hFF};
      send_buffer(seq);
      wait_drained();

      // Single wildcard byte matches the first byte
      apply_setting('1, '1, '0, 5'd1);
      seq = '{8'h5A};
      send_buffer(seq);
      wait_drained();

      // Random buffers across a series of register settings and idle phases
      for (int s = 0; s < 12; s++) begin
         len = LEN_W'($urandom_range(1, MAX_PATTERN_BYTES));
         case (s)
            0: apply_setting({$urandom, $urandom}, {$urandom, $urandom}, '1, 5'd16);
            1: apply_setting({$urandom, $urandom}, {$urandom, $urandom}, '0, 5'd16);
            2: apply_setting({$urandom, $urandom}, {$urandom, $urandom}, 16'h0001, 5'd1);
            3: apply_setting({$urandom, $urandom}, {$urandom, $urandom}, '1, 5'd0);
            4: apply_setting('0, '0, '0, LEN_W'($urandom_range(17, 31)));
            5: apply_setting('1, '1, STRICT_W'($urandom), len);
            6: apply_setting('0, '0, STRICT_W'($urandom), len);
            default: apply_setting({$urandom, $urandom}, {$urandom, $urandom},
                                   STRICT_W'($urandom), len);
         endcase
         case (s % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 77; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 77; end
            default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
         endcase
         setting_bytes = bytes_sent;
         while (bytes_sent - setting_bytes < 170) begin
            send_random_buffer();
            if ($urandom_range(9) == 0) wait_drained();
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/mbpf_pkg.sv
rtl/mbpf_if.sv
rtl/mbpf_csr.sv
rtl/mbpf_scan.sv
rtl/mbpf_out.sv
rtl/masked_byte_pattern_finder_top.sv
test/mbpf_match_monitor.sv
test/tb_top.sv
